// ----- rtl/mtp_pkg.sv -----
// mtp_pkg: shared types, codes and constants of the midi track note pairing parser
// no dependencies; compiled first
package mtp_pkg;

	localparam int STACK_SLOTS       = 2048;
	localparam int SLOT_W            = 11;
	localparam int STACK_DEPTH_DEF   = 8;
	localparam int EPOCH_W           = 8;

	localparam logic [7:0] DATA_MASK   = 8'h7F;
	localparam logic [7:0] META_BYTE   = 8'hFF;
	localparam logic [7:0] META_END    = 8'h2F;
	localparam logic [7:0] META_TEMPO  = 8'h51;

	localparam logic [1:0] KIND_NOTE  = 2'd0;
	localparam logic [1:0] KIND_TEMPO = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef enum logic [4:0] {
		PH_SEEK, PH_DELTA, PH_STATUS, PH_ON_KEY, PH_ON_VEL, PH_OFF_KEY, PH_OFF_VEL,
		PH_SKIP, PH_SKIP_LEN, PH_META_TYPE, PH_END_LEN, PH_TEMPO_LEN, PH_TEMPO_DATA,
		PH_RECOVER, PH_RECOVER_TAIL
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [31:0] start_tick;
		logic [31:0] duration_or_tempo;
		logic [6:0]  note_key;
		logic [3:0]  note_channel;
		logic [15:0] track_number;
		logic [6:0]  note_velocity;
	} record_t;

	// one parsed action toward the note stack
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
		logic              push;
		logic              pop;
		logic              tempo;
		logic              trk_end;
		logic              new_track;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       tick;
		logic [31:0]       tempo_val;
		logic [6:0]        vel;
		logic [15:0]       track;
	} stack_op_t;

	function automatic logic [7:0] tag_byte(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h54;
			2'd2: r = 8'h72;
			2'd3: r = 8'h6B;
			default: r = 8'h4D;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/mtp_stream_if.sv -----
// mtp_stream_if: valid/ready channel carrying one payload beat
// payload type is given at instantiation, usually from mtp_pkg
interface mtp_stream_if #(parameter type payload_t = logic [7:0]) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/mtp_parser.sv -----
// mtp_parser: byte level track parser, tick and length counters, track counter
// depends on mtp_pkg; drives stack operations into mtp_note_stack
module mtp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	output mtp_pkg::stack_op_t  op
);
	import mtp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  tag_q, tag_n;
	logic [7:0]  rs_q, rs_n;
	logic [31:0] tick_q, tick_n;
	logic [31:0] len_q, len_n;
	logic [31:0] skip_q, skip_n;
	logic [6:0]  key_q, key_n;
	logic [15:0] hist_q, hist_n;
	logic [15:0] trk_q, trk_n;

	logic [31:0] vlv;
	logic [31:0] skip_dec;
	logic [31:0] tempo_val;
	logic        tag_hit;
	logic        end_hit;
	logic        bad_phase;
	logic        stray_data;
	logic        rs_note;

	assign vlv        = {len_q[24:0], data_byte[6:0]};
	assign skip_dec   = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
	assign tempo_val  = {8'h00, len_q[15:0], data_byte};
	assign tag_hit    = (data_byte == tag_byte(tag_q[1:0]));
	assign end_hit    = accept && (((phase_q == PH_END_LEN) && !data_byte[7]) ||
		(phase_q == PH_RECOVER_TAIL));
	assign bad_phase  = accept && (phase_q > PH_RECOVER_TAIL);
	// data or F8..FE sitting where a status byte was expected
	assign stray_data = !data_byte[7] || ((data_byte[7:3] == 5'b11111) && (data_byte != META_BYTE));
	assign rs_note    = (rs_q[7:5] == 3'b100);

	// next state
	always_comb begin
		phase_n = phase_q;
		tag_n   = tag_q;
		rs_n    = rs_q;
		tick_n  = tick_q;
		len_n   = len_q;
		skip_n  = skip_q;
		key_n   = key_q;
		hist_n  = hist_q;
		trk_n   = trk_q;
		if (cfg_we) begin
			trk_n = cfg_wdata;
		end
		if (accept) begin
			unique case (phase_q)
				PH_SEEK: begin
					if (tag_hit) begin
						tag_n = tag_q + 3'd1;
					end else begin
						tag_n = (data_byte == tag_byte(2'd0)) ? 3'd1 : 3'd0;
					end
					if (tag_n == 3'd4) begin
						tag_n   = 3'd0;
						skip_n  = 32'd4;
						phase_n = PH_SKIP;
					end
				end
				PH_DELTA: begin
					len_n = vlv;
					if (!data_byte[7]) begin
						tick_n  = tick_q + vlv;
						len_n   = 32'd0;
						phase_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					len_n = 32'd0;
					priority if (data_byte[7:4] == 4'h8) begin
						rs_n = data_byte; phase_n = PH_OFF_KEY;
					end else if (data_byte[7:4] == 4'h9) begin
						rs_n = data_byte; phase_n = PH_ON_KEY;
					end else if (data_byte[7:4] == 4'hA || data_byte[7:4] == 4'hB ||
						data_byte[7:4] == 4'hE) begin
						rs_n = data_byte; skip_n = 32'd2; phase_n = PH_SKIP;
					end else if (data_byte[7:4] == 4'hC || data_byte[7:4] == 4'hD) begin
						rs_n = data_byte; skip_n = 32'd1; phase_n = PH_SKIP;
					end else if (data_byte[7:3] == 5'b11110) begin
						rs_n = 8'h00; phase_n = PH_SKIP_LEN;
					end else if (data_byte == META_BYTE) begin
						rs_n = 8'h00; phase_n = PH_META_TYPE;
					end else if (rs_q[7:4] == 4'h8) begin
						key_n = data_byte[6:0]; phase_n = PH_OFF_VEL;
					end else if (rs_q[7:4] == 4'h9) begin
						key_n = data_byte[6:0]; phase_n = PH_ON_VEL;
					end else if (rs_q[7:4] == 4'hA || rs_q[7:4] == 4'hB ||
						rs_q[7:4] == 4'hE) begin
						skip_n = 32'd1; phase_n = PH_SKIP;
					end else if (rs_q[7:4] == 4'hC || rs_q[7:4] == 4'hD) begin
						phase_n = PH_DELTA;
					end else begin
						hist_n = 16'h0000; phase_n = PH_RECOVER;
					end
				end
				PH_ON_KEY: begin
					key_n = data_byte[6:0]; phase_n = PH_ON_VEL;
				end
				PH_OFF_KEY: begin
					key_n = data_byte[6:0]; phase_n = PH_OFF_VEL;
				end
				PH_ON_VEL, PH_OFF_VEL: begin
					phase_n = PH_DELTA;
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 32'd0) begin
						phase_n = PH_DELTA;
					end
				end
				PH_SKIP_LEN: begin
					len_n = vlv;
					if (!data_byte[7]) begin
						len_n = 32'd0;
						if (vlv == 32'd0) begin
							phase_n = PH_DELTA;
						end else begin
							skip_n  = vlv;
							phase_n = PH_SKIP;
						end
					end
				end
				PH_META_TYPE: begin
					len_n = 32'd0;
					priority if (data_byte == META_END) begin
						phase_n = PH_END_LEN;
					end else if (data_byte == META_TEMPO) begin
						phase_n = PH_TEMPO_LEN;
					end else begin
						phase_n = PH_SKIP_LEN;
					end
				end
				PH_END_LEN: begin
				end
				PH_TEMPO_LEN: begin
					len_n = 32'd0; skip_n = 32'd3; phase_n = PH_TEMPO_DATA;
				end
				PH_TEMPO_DATA: begin
					len_n  = tempo_val;
					skip_n = skip_dec;
					if (skip_dec == 32'd0) begin
						len_n = 32'd0; phase_n = PH_DELTA;
					end
				end
				PH_RECOVER: begin
					if (data_byte == META_END && hist_q[15:8] == META_BYTE && hist_q[7:0] == 8'h00) begin
						phase_n = PH_RECOVER_TAIL;
					end
					hist_n = {data_byte, hist_q[15:8]};
				end
				PH_RECOVER_TAIL: begin
				end
				default: begin
				end
			endcase
			if (end_hit) begin
				trk_n = trk_q + 16'd1;
			end
			if (end_hit || bad_phase) begin
				phase_n = PH_SEEK;
				tag_n   = 3'd0;
				rs_n    = 8'h00;
				tick_n  = 32'd0;
				len_n   = 32'd0;
				skip_n  = 32'd0;
				key_n   = 7'd0;
				hist_n  = 16'h0000;
			end
		end
	end

	// stack operations
	always_comb begin
		op           = '0;
		op.rd_slot   = {rs_q[3:0], data_byte[6:0]};
		op.slot      = {rs_q[3:0], key_q};
		op.tick      = tick_q;
		op.tempo_val = tempo_val;
		op.vel       = data_byte[6:0];
		op.track     = trk_q;
		if (accept) begin
			op.rd_en     = (phase_q == PH_ON_KEY) || (phase_q == PH_OFF_KEY) ||
				((phase_q == PH_STATUS) && stray_data && rs_note);
			op.push      = (phase_q == PH_ON_VEL) && (data_byte[6:0] != 7'd0);
			op.pop       = ((phase_q == PH_ON_VEL) && (data_byte[6:0] == 7'd0)) ||
				(phase_q == PH_OFF_VEL);
			op.tempo     = (phase_q == PH_TEMPO_DATA) && (skip_dec == 32'd0);
			op.trk_end   = end_hit;
			op.new_track = end_hit || bad_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			tag_q   <= 3'd0;
			rs_q    <= 8'h00;
			tick_q  <= 32'd0;
			len_q   <= 32'd0;
			skip_q  <= 32'd0;
			key_q   <= 7'd0;
			hist_q  <= 16'h0000;
			trk_q   <= 16'd2;
		end else begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			rs_q    <= rs_n;
			tick_q  <= tick_n;
			len_q   <= len_n;
			skip_q  <= skip_n;
			key_q   <= key_n;
			hist_q  <= hist_n;
			trk_q   <= trk_n;
		end
	end

endmodule

// ----- rtl/mtp_note_stack.sv -----
// mtp_note_stack: per channel/key open note stacks in two synchronous memories
// depends on mtp_pkg; slot header memory with epoch tags, note memory, result stage s1
module mtp_note_stack #(
	parameter int STACK_DEPTH = mtp_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtp_pkg::stack_op_t  op,
	output logic                busy,
	output logic                rec_valid,
	output mtp_pkg::record_t    rec
);
	import mtp_pkg::*;

	localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int NOTES   = STACK_SLOTS * STACK_DEPTH;
	localparam int NOTE_AW = $clog2(NOTES);

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [PTR_W-1:0]   head;
		logic [CNT_W-1:0]   cnt;
	} slot_hdr_t;

	typedef struct packed {
		logic [6:0]  vel;
		logic [31:0] tick;
	} note_t;

	slot_hdr_t hdr_mem [STACK_SLOTS];
	note_t     note_mem [NOTES];

	slot_hdr_t          hdr_rd_q;
	note_t              note_rd_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clr_busy_q;
	logic [SLOT_W-1:0]  clr_idx_q;

	logic [PTR_W-1:0]   head;
	logic [CNT_W-1:0]   cnt;
	logic               full;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   sum_wrap;
	logic [PTR_W-1:0]   pos;
	logic [PTR_W-1:0]   head_inc;
	slot_hdr_t          hdr_wr;
	logic               hdr_we;
	logic               pop_hit;
	logic [NOTE_AW-1:0] note_addr;

	logic               s1_valid;
	logic [1:0]         kind_s1;
	logic [31:0]        tick_s1;
	logic [31:0]        val_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [15:0]        track_s1;

	// a header from an older track reads as an empty stack
	assign head     = (hdr_rd_q.epoch == epoch_q) ? hdr_rd_q.head : '0;
	assign cnt      = (hdr_rd_q.epoch == epoch_q) ? hdr_rd_q.cnt : '0;
	assign full     = (cnt >= CNT_W'(STACK_DEPTH));
	assign sum      = op.push ? SUM_W'(head) + SUM_W'(cnt) : SUM_W'(head) + SUM_W'(cnt) - SUM_W'(1);
	assign sum_wrap = (sum >= SUM_W'(STACK_DEPTH)) ? sum - SUM_W'(STACK_DEPTH) : sum;
	assign head_inc = (head == PTR_W'(STACK_DEPTH - 1)) ? '0 : head + PTR_W'(1);
	assign pop_hit  = op.pop && (cnt != '0);

	always_comb begin
		hdr_wr.epoch = epoch_q;
		hdr_wr.head  = head;
		hdr_wr.cnt   = cnt;
		pos          = PTR_W'(sum_wrap);
		if (op.push) begin
			if (full) begin
				// overwrite the oldest entry and move the bottom up
				pos         = head;
				hdr_wr.head = head_inc;
			end else begin
				hdr_wr.cnt = cnt + CNT_W'(1);
			end
		end else begin
			hdr_wr.cnt = cnt - CNT_W'(1);
		end
	end

	assign hdr_we    = op.push || pop_hit;
	assign note_addr = NOTE_AW'(op.slot) * NOTE_AW'(STACK_DEPTH) + NOTE_AW'(pos);
	assign busy      = clr_busy_q;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			hdr_mem[clr_idx_q] <= '{epoch: epoch_q, head: '0, cnt: '0};
		end else if (hdr_we) begin
			hdr_mem[op.slot] <= hdr_wr;
		end
		if (op.rd_en) begin
			hdr_rd_q <= hdr_mem[op.rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			note_mem[note_addr] <= '{vel: op.vel, tick: op.tick};
		end
		if (pop_hit) begin
			note_rd_q <= note_mem[note_addr];
		end
	end

	// epoch advances per track; a full clearing sweep runs after reset and on epoch wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
				if (clr_idx_q == SLOT_W'(STACK_SLOTS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end else if (op.new_track) begin
				epoch_q <= epoch_q + EPOCH_W'(1);
				if (epoch_q == '1) begin
					clr_busy_q <= 1'b1;
					clr_idx_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= pop_hit || op.tempo || op.trk_end;
		end
	end

	always_ff @(posedge clk) begin
		priority if (op.tempo) begin
			kind_s1 <= KIND_TEMPO;
		end else if (op.trk_end) begin
			kind_s1 <= KIND_END;
		end else begin
			kind_s1 <= KIND_NOTE;
		end
		tick_s1  <= op.tick;
		val_s1   <= op.tempo_val;
		slot_s1  <= op.slot;
		track_s1 <= op.track;
	end

	always_comb begin
		rec = '0;
		rec.record_kind = kind_s1;
		unique case (kind_s1)
			KIND_NOTE: begin
				rec.start_tick        = note_rd_q.tick;
				rec.duration_or_tempo = tick_s1 - note_rd_q.tick;
				rec.note_key          = slot_s1[6:0];
				rec.note_channel      = slot_s1[10:7];
				rec.track_number      = track_s1;
				rec.note_velocity     = note_rd_q.vel;
			end
			KIND_TEMPO: begin
				rec.start_tick        = tick_s1;
				rec.duration_or_tempo = val_s1;
			end
			KIND_END: begin
				rec.track_number      = track_s1;
			end
			default: begin
			end
		endcase
	end

	assign rec_valid = s1_valid;

endmodule

// ----- rtl/mtp_out_fifo.sv -----
// mtp_out_fifo: two entry output queue decoupling the record stage from the sink
// depends on mtp_pkg and mtp_stream_if
module mtp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mtp_pkg::record_t  push_rec,
	output logic [1:0]        level,
	mtp_stream_if.source      rec_chan
);
	import mtp_pkg::*;

	record_t    slot_mem [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;

	assign pop              = rec_chan.valid && rec_chan.ready;
	assign rec_chan.valid   = (cnt_q != 2'd0);
	assign rec_chan.payload = slot_mem[rd_q];
	assign level            = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_mem[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/midi_track_note_pairing_parser.sv -----
// midi_track_note_pairing_parser: MTrk parser pairing note-on/off in per slot stacks
// a record reaches rec_chan through the record stage s1 and then the output queue after the byte beat that completes it
// throughput: one byte beat per cycle; input stalls while queue and record stage hold two
// reset: arst_n resets all control state (track counter to 2), then a sweep clears all 2048 slot headers
// the same sweep (no byte beats taken) repeats after every 256 track ends
// depends on mtp_pkg, mtp_stream_if, mtp_parser, mtp_note_stack, mtp_out_fifo
module midi_track_note_pairing_parser #(
	parameter int STACK_DEPTH = mtp_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	mtp_stream_if.sink   data_chan,
	mtp_stream_if.source rec_chan
);
	import mtp_pkg::*;

	stack_op_t  op;
	record_t    rec;
	logic       rec_valid;
	logic       busy;
	logic [1:0] level;
	logic       accept;

	// room for every record that may still be in flight
	assign data_chan.ready = !busy && ((level == 2'd0) || ((level == 2'd1) && !rec_valid));
	assign accept          = data_chan.valid && data_chan.ready;

	mtp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.data_byte (data_chan.payload.data_byte),
		.op        (op)
	);

	mtp_note_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.busy      (busy),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	mtp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_valid),
		.push_rec (rec),
		.level    (level),
		.rec_chan (rec_chan)
	);

endmodule
